@@ hdl/segci_pkg.sv @@
// segci_pkg: shared types and constants for the segment/circle intersection block
// depends on nothing; used by segci_front, segment_circle_intersect_top and the bench
`default_nettype none

package segci_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_AMBIG   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN   = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
   } ctl_type;

endpackage

`default_nettype wire

@@ hdl/segci_front.sv @@
// segci_front: six-stage setup pipeline, forms a, b, c and the discriminant
// depends on segci_pkg
`default_nettype none

module segci_front #(
   parameter int CW = segci_pkg::COORD_BITS_DEFAULT,
   localparam int H = CW + 1,
   localparam int AW = 2 * CW + 2,
   localparam int BW = 2 * CW + 3,
   localparam int VW = 4 * CW + 5,
   localparam int FS_W = 2 * CW + 2 * H
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [CW-1:0]    in_x1,
   input  logic signed [CW-1:0]    in_y1,
   input  logic signed [CW-1:0]    in_x2,
   input  logic signed [CW-1:0]    in_y2,
   input  logic signed [CW-1:0]    in_cx,
   input  logic signed [CW-1:0]    in_cy,
   input  logic        [CW-2:0]    in_r,
   output segci_pkg::ctl_type      out_ctl,
   output logic        [VW-1:0]    out_disc,
   output logic        [AW-1:0]    out_a,
   output logic        [BW-1:0]    out_b,
   output logic        [FS_W-1:0]  out_side
);

   localparam int RRW = 2 * CW - 2;
   localparam int QW4 = 4 * H;
   localparam int DSW = 4 * H + 3;
   localparam int PW  = 2 * H;

   // stage 0
   logic                  v0_ff;
   logic [CW-1:0]         x1_0_ff, y1_0_ff;
   logic signed [H-1:0]   dx0_ff, dy0_ff, ex0_ff, ey0_ff;
   logic [CW-2:0]         r0_ff;
   // stage 1
   logic                  v1_ff;
   logic [FS_W-1:0]       side1_ff;
   logic signed [2*H-1:0] pdxdx_ff, pdydy_ff, pdxex_ff, pdyey_ff, pexex_ff, peyey_ff;
   logic [RRW-1:0]        prr_ff;
   // stage 2
   logic                  v2_ff;
   logic [FS_W-1:0]       side2_ff;
   logic [AW-1:0]         a2_ff;
   logic [BW-1:0]         b2_ff, c2_ff;
   logic [BW-1:0]         bsum_in;
   // stage 3
   logic                  v3_ff, cneg3_ff, azero3_ff;
   logic [FS_W-1:0]       side3_ff;
   logic [AW-1:0]         a3_ff;
   logic [BW-1:0]         b3_ff;
   logic [2*H-1:0]        bll_ff, blh_ff, bhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [BW-1:0]         bneg_in, cneg_in;
   logic [2*H-1:0]        bmag_in, cmag_in;
   // stage 4
   logic                  v4_ff, cneg4_ff, azero4_ff;
   logic [FS_W-1:0]       side4_ff;
   logic [AW-1:0]         a4_ff;
   logic [BW-1:0]         b4_ff;
   logic [QW4-1:0]        bsq4_ff, ac4_ff;
   // stage 5
   logic                  v5_ff;
   logic [segci_pkg::STATUS_W-1:0] status5_ff;
   logic [VW-1:0]         disc5_ff;
   logic [AW-1:0]         a5_ff;
   logic [BW-1:0]         b5_ff;
   logic [FS_W-1:0]       side5_ff;
   logic [DSW-1:0]        bsq_e, ac_e, disc_in;
   logic [segci_pkg::STATUS_W-1:0] status_in;

   assign bsum_in = {{(BW-2*H){pdxex_ff[2*H-1]}}, pdxex_ff}
                  + {{(BW-2*H){pdyey_ff[2*H-1]}}, pdyey_ff};
   assign bneg_in = -b2_ff;
   assign cneg_in = -c2_ff;
   assign bmag_in = b2_ff[BW-1] ? bneg_in[2*H-1:0] : b2_ff[2*H-1:0];
   assign cmag_in = c2_ff[BW-1] ? cneg_in[2*H-1:0] : c2_ff[2*H-1:0];

   assign bsq_e = {3'b000, bsq4_ff};
   assign ac_e  = {1'b0, ac4_ff, 2'b00};
   assign disc_in = cneg4_ff ? (bsq_e + ac_e) : (bsq_e - ac_e);

   always_comb begin
      priority if (azero4_ff) begin
         status_in = segci_pkg::STATUS_DEGEN;
      end else if (disc_in[DSW-1]) begin
         status_in = segci_pkg::STATUS_NO_ROOT;
      end else begin
         status_in = segci_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_0_ff <= in_x1;
      y1_0_ff <= in_y1;
      dx0_ff  <= {in_x2[CW-1], in_x2} - {in_x1[CW-1], in_x1};
      dy0_ff  <= {in_y2[CW-1], in_y2} - {in_y1[CW-1], in_y1};
      ex0_ff  <= {in_x1[CW-1], in_x1} - {in_cx[CW-1], in_cx};
      ey0_ff  <= {in_y1[CW-1], in_y1} - {in_cy[CW-1], in_cy};
      r0_ff   <= in_r;

      side1_ff <= {x1_0_ff, y1_0_ff, dx0_ff, dy0_ff};
      pdxdx_ff <= PW'(dx0_ff) * PW'(dx0_ff);
      pdydy_ff <= PW'(dy0_ff) * PW'(dy0_ff);
      pdxex_ff <= PW'(dx0_ff) * PW'(ex0_ff);
      pdyey_ff <= PW'(dy0_ff) * PW'(ey0_ff);
      pexex_ff <= PW'(ex0_ff) * PW'(ex0_ff);
      peyey_ff <= PW'(ey0_ff) * PW'(ey0_ff);
      prr_ff   <= RRW'(r0_ff) * RRW'(r0_ff);

      side2_ff <= side1_ff;
      a2_ff    <= pdxdx_ff[AW-1:0] + pdydy_ff[AW-1:0];
      b2_ff    <= {bsum_in[BW-2:0], 1'b0};
      c2_ff    <= {{(BW-2*H){pexex_ff[2*H-1]}}, pexex_ff}
                + {{(BW-2*H){peyey_ff[2*H-1]}}, peyey_ff}
                - {{(BW-RRW){1'b0}}, prr_ff};

      side3_ff  <= side2_ff;
      a3_ff     <= a2_ff;
      b3_ff     <= b2_ff;
      cneg3_ff  <= c2_ff[BW-1];
      azero3_ff <= (a2_ff == '0);
      bll_ff    <= PW'(bmag_in[H-1:0]) * PW'(bmag_in[H-1:0]);
      blh_ff    <= PW'(bmag_in[H-1:0]) * PW'(bmag_in[2*H-1:H]);
      bhh_ff    <= PW'(bmag_in[2*H-1:H]) * PW'(bmag_in[2*H-1:H]);
      all_ff    <= PW'(a2_ff[H-1:0]) * PW'(cmag_in[H-1:0]);
      alh_ff    <= PW'(a2_ff[H-1:0]) * PW'(cmag_in[2*H-1:H]);
      ahl_ff    <= PW'(a2_ff[2*H-1:H]) * PW'(cmag_in[H-1:0]);
      ahh_ff    <= PW'(a2_ff[2*H-1:H]) * PW'(cmag_in[2*H-1:H]);

      side4_ff  <= side3_ff;
      a4_ff     <= a3_ff;
      b4_ff     <= b3_ff;
      cneg4_ff  <= cneg3_ff;
      azero4_ff <= azero3_ff;
      bsq4_ff   <= (QW4'(bhh_ff) << (2 * H)) + (QW4'(blh_ff) << (H + 1)) + QW4'(bll_ff);
      ac4_ff    <= (QW4'(ahh_ff) << (2 * H)) + ((QW4'(alh_ff) + QW4'(ahl_ff)) << H)
                 + QW4'(all_ff);

      side5_ff   <= side4_ff;
      a5_ff      <= a4_ff;
      b5_ff      <= b4_ff;
      status5_ff <= status_in;
      disc5_ff   <= disc_in[DSW-1] ? '0 : disc_in[VW-1:0];
   end

   assign out_ctl  = {v5_ff, status5_ff};
   assign out_disc = disc5_ff;
   assign out_a    = a5_ff;
   assign out_b    = b5_ff;
   assign out_side = side5_ff;

endmodule

`default_nettype wire

@@ hdl/segci_sqrt_cell.sv @@
// segci_sqrt_cell: one bit of the integer square root, one register stage
// depends on nothing; chained by segment_circle_intersect_top
`default_nettype none

module segci_sqrt_cell #(
   parameter int VW = 69,
   parameter int RW = 35,
   parameter int BIT = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [VW-1:0]     in_rem,
   input  logic [RW-1:0]     in_root,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [VW-1:0]     out_rem,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TW = VW + 2;

   logic              valid_ff;
   logic [VW-1:0]     rem_ff;
   logic [RW-1:0]     root_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [TW-1:0]     trial, rem_e, diff;
   logic              take;

   assign trial = (TW'(in_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
   assign rem_e = TW'(in_rem);
   assign take  = rem_e >= trial;
   assign diff  = rem_e - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= take ? diff[VW-1:0] : in_rem;
      root_ff <= take ? (in_root | (RW'(1) << BIT)) : in_root;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

@@ hdl/segci_div_cell.sv @@
// segci_div_cell: one quotient bit of two restoring divisions sharing a divisor
// depends on nothing; chained by segment_circle_intersect_top
`default_nettype none

module segci_div_cell #(
   parameter int NMW = 51,
   parameter int DVW = 34,
   parameter int QW = 17,
   parameter int BIT = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVW-1:0]    in_d,
   input  logic [NMW-1:0]    in_remx,
   input  logic [NMW-1:0]    in_remy,
   input  logic [QW-1:0]     in_qx,
   input  logic [QW-1:0]     in_qy,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DVW-1:0]    out_d,
   output logic [NMW-1:0]    out_remx,
   output logic [NMW-1:0]    out_remy,
   output logic [QW-1:0]     out_qx,
   output logic [QW-1:0]     out_qy,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TW = ((NMW > DVW + QW) ? NMW : DVW + QW) + 1;

   logic              valid_ff;
   logic [DVW-1:0]    d_ff;
   logic [NMW-1:0]    remx_ff, remy_ff;
   logic [QW-1:0]     qx_ff, qy_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [TW-1:0]     trial, remx_e, remy_e, diffx, diffy;
   logic              takex, takey;

   assign trial  = TW'(in_d) << BIT;
   assign remx_e = TW'(in_remx);
   assign remy_e = TW'(in_remy);
   assign takex  = remx_e >= trial;
   assign takey  = remy_e >= trial;
   assign diffx  = remx_e - trial;
   assign diffy  = remy_e - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= in_d;
      remx_ff <= takex ? diffx[NMW-1:0] : in_remx;
      remy_ff <= takey ? diffy[NMW-1:0] : in_remy;
      qx_ff   <= takex ? (in_qx | (QW'(1) << BIT)) : in_qx;
      qy_ff   <= takey ? (in_qy | (QW'(1) << BIT)) : in_qy;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_d     = d_ff;
   assign out_remx  = remx_ff;
   assign out_remy  = remy_ff;
   assign out_qx    = qx_ff;
   assign out_qy    = qy_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

@@ hdl/segment_circle_intersect_top.sv @@
// segment_circle_intersect_top: segment/circle intersection, exact integer pipeline
// depends on segci_pkg, segci_front, segci_sqrt_cell, segci_div_cell
//
// Usage: one request word carries a segment (start, end) and a circle (centre,
// radius); one response word carries the hit point and a status code
// (ok, no real root, zero or two roots on the segment, degenerate segment).
// Both channels are valid/ready. A request is taken in any cycle that ready is
// high, so a new word can enter every clock.
// From request to response valid a word passes six setup stages (the first
// loads at the accepting edge), a square root chain of 2*COORD_BITS+3 cells,
// four select and multiply stages, a divider chain of COORD_BITS+1 cells,
// one sign restore stage, the buffer write and the output register.
// Finished words land in a result buffer in front of the output register.
// Ready stays high while fewer than DEPTH words are in flight or buffered, so
// a stalled receiver does not stop intake until the buffer would fill; then
// ready drops and resumes as the receiver takes words.
// Reset clears all valid bits, the buffer pointers and the word counters;
// no clearing pass is needed.
`default_nettype none

module segment_circle_intersect_top #(
   parameter int COORD_BITS = segci_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic signed [COORD_BITS-1:0]  req_centre_x,
   input  logic signed [COORD_BITS-1:0]  req_centre_y,
   input  logic        [COORD_BITS-2:0]  req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_hit_x,
   output logic signed [COORD_BITS-1:0]  rsp_hit_y,
   output logic [segci_pkg::STATUS_W-1:0] rsp_status
);

   localparam int C     = COORD_BITS;
   localparam int SW_   = segci_pkg::STATUS_W;
   localparam int H     = C + 1;
   localparam int AW    = 2 * C + 2;
   localparam int BW    = 2 * C + 3;
   localparam int VW    = 4 * C + 5;
   localparam int RW    = 2 * C + 3;
   localparam int NNW   = 2 * C + 5;
   localparam int PXW   = 2 * C + 2;
   localparam int PDW   = 2 * C + 3;
   localparam int NW    = 3 * C + 4;
   localparam int NMW   = 3 * C + 3;
   localparam int QW    = C + 1;
   localparam int FS_W  = 2 * C + 2 * H;
   localparam int SQS_W = SW_ + AW + BW + FS_W;
   localparam int DVS_W = SW_ + 2;
   localparam int LAT   = 3 * C + 15;
   localparam int DEPTH = 1 << $clog2(LAT + 2);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int PL_W  = 2 * C + SW_;

   // setup
   segci_pkg::ctl_type f_ctl;
   logic [VW-1:0]      f_disc;
   logic [AW-1:0]      f_a;
   logic [BW-1:0]      f_b;
   logic [FS_W-1:0]    f_side;

   segci_front #(.CW(C)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid && req_ready),
      .in_x1    (req_start_x),
      .in_y1    (req_start_y),
      .in_x2    (req_end_x),
      .in_y2    (req_end_y),
      .in_cx    (req_centre_x),
      .in_cy    (req_centre_y),
      .in_r     (req_radius),
      .out_ctl  (f_ctl),
      .out_disc (f_disc),
      .out_a    (f_a),
      .out_b    (f_b),
      .out_side (f_side)
   );

   // square root chain
   logic             sq_valid [0:RW];
   logic [VW-1:0]    sq_rem   [0:RW];
   logic [RW-1:0]    sq_root  [0:RW];
   logic [SQS_W-1:0] sq_side  [0:RW];

   assign sq_valid[0] = f_ctl.valid;
   assign sq_rem[0]   = f_disc;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {f_ctl.status, f_a, f_b, f_side};

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      segci_sqrt_cell #(.VW(VW), .RW(RW), .BIT(RW - 1 - k), .SIDE_W(SQS_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_valid[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // root select
   logic [SQS_W-1:0] e_side;
   logic [SW_-1:0]   e_status;
   logic [AW-1:0]    e_a, e_two_a;
   logic [BW-1:0]    e_b;
   logic [NNW-1:0]   nb, s_e, n1, n2;
   logic             v1, v2;
   logic [SW_-1:0]   sel_status_in;

   assign e_side   = sq_side[RW];
   assign e_status = e_side[SQS_W-1 -: SW_];
   assign e_a      = e_side[SQS_W-SW_-1 -: AW];
   assign e_b      = e_side[BW+FS_W-1 -: BW];
   assign e_two_a  = {e_a[AW-2:0], 1'b0};
   assign nb       = -{{(NNW-BW){e_b[BW-1]}}, e_b};
   assign s_e      = {{(NNW-RW){1'b0}}, sq_root[RW]};
   assign n1       = nb + s_e;
   assign n2       = nb - s_e;
   assign v1       = !n1[NNW-1] && (n1 <= {{(NNW-AW){1'b0}}, e_two_a});
   assign v2       = !n2[NNW-1] && (n2 <= {{(NNW-AW){1'b0}}, e_two_a});

   always_comb begin
      priority if (e_status != segci_pkg::STATUS_OK) begin
         sel_status_in = e_status;
      end else if (v1 == v2) begin
         sel_status_in = segci_pkg::STATUS_AMBIG;
      end else begin
         sel_status_in = segci_pkg::STATUS_OK;
      end
   end

   logic                sel_valid_ff;
   logic [SW_-1:0]      sel_status_ff;
   logic [AW-1:0]       sel_two_a_ff, sel_num_ff;
   logic [FS_W-1:0]     sel_side_ff;
   logic signed [C-1:0] sel_x1, sel_y1;
   logic signed [H-1:0] sel_dx, sel_dy;

   assign sel_x1 = sel_side_ff[FS_W-1 -: C];
   assign sel_y1 = sel_side_ff[FS_W-C-1 -: C];
   assign sel_dx = sel_side_ff[2*H-1 -: H];
   assign sel_dy = sel_side_ff[H-1:0];

   // partial products
   logic                  pt_valid_ff;
   logic [SW_-1:0]        pt_status_ff;
   logic [AW-1:0]         pt_two_a_ff;
   logic signed [PXW-1:0] pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic signed [PDW-1:0] pdxl_ff, pdxh_ff, pdyl_ff, pdyh_ff;
   logic signed [H:0]     ta_lo, ta_hi, nm_lo, nm_hi;

   assign ta_lo = {1'b0, sel_two_a_ff[H-1:0]};
   assign ta_hi = {1'b0, sel_two_a_ff[AW-1:H]};
   assign nm_lo = {1'b0, sel_num_ff[H-1:0]};
   assign nm_hi = {1'b0, sel_num_ff[AW-1:H]};

   // numerator sums
   logic            sm_valid_ff;
   logic [SW_-1:0]  sm_status_ff;
   logic [AW-1:0]   sm_two_a_ff;
   logic [NW-1:0]   sm_nx_ff, sm_ny_ff;
   logic [NW-1:0]   nx_in, ny_in, nx_neg, ny_neg;

   assign nx_in = {{(NW-PXW){pxl_ff[PXW-1]}}, pxl_ff}
                + ({{(NW-PXW){pxh_ff[PXW-1]}}, pxh_ff} << H)
                + {{(NW-PDW){pdxl_ff[PDW-1]}}, pdxl_ff}
                + ({{(NW-PDW){pdxh_ff[PDW-1]}}, pdxh_ff} << H);
   assign ny_in = {{(NW-PXW){pyl_ff[PXW-1]}}, pyl_ff}
                + ({{(NW-PXW){pyh_ff[PXW-1]}}, pyh_ff} << H)
                + {{(NW-PDW){pdyl_ff[PDW-1]}}, pdyl_ff}
                + ({{(NW-PDW){pdyh_ff[PDW-1]}}, pdyh_ff} << H);
   assign nx_neg = -sm_nx_ff;
   assign ny_neg = -sm_ny_ff;

   // magnitude and sign
   logic            ab_valid_ff, ab_negx_ff, ab_negy_ff;
   logic [SW_-1:0]  ab_status_ff;
   logic [AW-1:0]   ab_two_a_ff;
   logic [NMW-1:0]  ab_magx_ff, ab_magy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
         pt_valid_ff  <= 1'b0;
         sm_valid_ff  <= 1'b0;
         ab_valid_ff  <= 1'b0;
      end else begin
         sel_valid_ff <= sq_valid[RW];
         pt_valid_ff  <= sel_valid_ff;
         sm_valid_ff  <= pt_valid_ff;
         ab_valid_ff  <= sm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sel_status_ff <= sel_status_in;
      sel_two_a_ff  <= e_two_a;
      sel_num_ff    <= v1 ? n1[AW-1:0] : n2[AW-1:0];
      sel_side_ff   <= e_side[FS_W-1:0];

      pt_status_ff <= sel_status_ff;
      pt_two_a_ff  <= sel_two_a_ff;
      pxl_ff       <= PXW'(sel_x1) * PXW'(ta_lo);
      pxh_ff       <= PXW'(sel_x1) * PXW'(ta_hi);
      pyl_ff       <= PXW'(sel_y1) * PXW'(ta_lo);
      pyh_ff       <= PXW'(sel_y1) * PXW'(ta_hi);
      pdxl_ff      <= PDW'(sel_dx) * PDW'(nm_lo);
      pdxh_ff      <= PDW'(sel_dx) * PDW'(nm_hi);
      pdyl_ff      <= PDW'(sel_dy) * PDW'(nm_lo);
      pdyh_ff      <= PDW'(sel_dy) * PDW'(nm_hi);

      sm_status_ff <= pt_status_ff;
      sm_two_a_ff  <= pt_two_a_ff;
      sm_nx_ff     <= nx_in;
      sm_ny_ff     <= ny_in;

      ab_status_ff <= sm_status_ff;
      ab_two_a_ff  <= sm_two_a_ff;
      ab_negx_ff   <= sm_nx_ff[NW-1];
      ab_negy_ff   <= sm_ny_ff[NW-1];
      ab_magx_ff   <= sm_nx_ff[NW-1] ? nx_neg[NMW-1:0] : sm_nx_ff[NMW-1:0];
      ab_magy_ff   <= sm_ny_ff[NW-1] ? ny_neg[NMW-1:0] : sm_ny_ff[NMW-1:0];
   end

   // divider chain
   logic             dv_valid [0:QW];
   logic [AW-1:0]    dv_d     [0:QW];
   logic [NMW-1:0]   dv_remx  [0:QW];
   logic [NMW-1:0]   dv_remy  [0:QW];
   logic [QW-1:0]    dv_qx    [0:QW];
   logic [QW-1:0]    dv_qy    [0:QW];
   logic [DVS_W-1:0] dv_side  [0:QW];

   assign dv_valid[0] = ab_valid_ff;
   assign dv_d[0]     = ab_two_a_ff;
   assign dv_remx[0]  = ab_magx_ff;
   assign dv_remy[0]  = ab_magy_ff;
   assign dv_qx[0]    = '0;
   assign dv_qy[0]    = '0;
   assign dv_side[0]  = {ab_status_ff, ab_negx_ff, ab_negy_ff};

   for (genvar k = 0; k < QW; k++) begin : g_div
      segci_div_cell #(
         .NMW(NMW), .DVW(AW), .QW(QW), .BIT(QW - 1 - k), .SIDE_W(DVS_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_d      (dv_d[k]),
         .in_remx   (dv_remx[k]),
         .in_remy   (dv_remy[k]),
         .in_qx     (dv_qx[k]),
         .in_qy     (dv_qy[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_d     (dv_d[k+1]),
         .out_remx  (dv_remx[k+1]),
         .out_remy  (dv_remy[k+1]),
         .out_qx    (dv_qx[k+1]),
         .out_qy    (dv_qy[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // sign restore and error zeroing
   logic [SW_-1:0]  fin_status_in;
   logic [QW-1:0]   rx, ry;
   logic [C-1:0]    hx_in, hy_in;
   logic            fin_valid_ff;
   logic [PL_W-1:0] fin_data_ff;

   assign fin_status_in = dv_side[QW][DVS_W-1 -: SW_];
   assign rx = dv_side[QW][1] ? -dv_qx[QW] : dv_qx[QW];
   assign ry = dv_side[QW][0] ? -dv_qy[QW] : dv_qy[QW];
   assign hx_in = (fin_status_in == segci_pkg::STATUS_OK) ? rx[C-1:0] : '0;
   assign hy_in = (fin_status_in == segci_pkg::STATUS_OK) ? ry[C-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      fin_data_ff <= {hx_in, hy_in, fin_status_in};
   end

   // result buffer and output register
   logic [PL_W-1:0]  mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fifo_cnt_ff, total_ff;
   logic             rsp_valid_ff;
   logic [PL_W-1:0]  rsp_data_ff;
   logic             push, pop, accept, deliver;

   assign push    = fin_valid_ff;
   assign pop     = (fifo_cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign accept  = req_valid && req_ready;
   assign deliver = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= fin_data_ff;
      end
      if (pop) begin
         rsp_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fifo_cnt_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(push) - CNT_W'(pop);
         total_ff    <= total_ff + CNT_W'(accept) - CNT_W'(deliver);
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready  = total_ff < CNT_W'(DEPTH);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit_x  = rsp_data_ff[PL_W-1 -: C];
   assign rsp_hit_y  = rsp_data_ff[PL_W-C-1 -: C];
   assign rsp_status = rsp_data_ff[SW_-1:0];

   // buffer never overflows
   assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff != CNT_W'(DEPTH)) || pop)
      else $error("result buffer overflow");

   // buffered and shown words are all counted as in flight
   assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(fifo_cnt_ff) + (CNT_W + 1)'(rsp_valid_ff) <= (CNT_W + 1)'(total_ff))
      else $error("word count below buffered words");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> total_ff != '0)
      else $error("accepted word not counted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != segci_pkg::STATUS_OK) |->
         (rsp_hit_x == '0) && (rsp_hit_y == '0))
      else $error("nonzero hit point on error status");

endmodule

`default_nettype wire

@@ tb/segment_circle_intersect_top_tb.sv @@
// segment_circle_intersect_top_tb: self-checking bench for the segment/circle intersection block
// depends on segci_pkg and segment_circle_intersect_top; exact integer hit-point predictor,
// valid/ready driver and monitor with random idling across four phases
`timescale 1ns / 1ps

module segment_circle_intersect_top_tb;

   localparam int CW = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] centre_x;
      logic signed [CW-1:0] centre_y;
      logic [CW-2:0]        radius;
   } query_type;

   typedef struct packed {
      logic signed [CW-1:0] hit_x;
      logic signed [CW-1:0] hit_y;
      logic [segci_pkg::STATUS_W-1:0] status;
   } hit_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [CW-1:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic signed [CW-1:0] req_centre_x, req_centre_y;
   logic [CW-2:0] req_radius;
   logic signed [CW-1:0] rsp_hit_x, rsp_hit_y;
   logic [segci_pkg::STATUS_W-1:0] rsp_status;

   query_type pending_queries[$];
   hit_type expected_hits[$];
   int sender_idle_pct, receiver_stall_pct;
   int mismatch_count, idle_cycles;

   segment_circle_intersect_top #(.COORD_BITS(CW)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_centre_x(req_centre_x), .req_centre_y(req_centre_y),
      .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_status(rsp_status)
   );

   function automatic hit_type predict_hit(input query_type q);
      longint dx, dy, ex, ey, rr, a, b, c;
      logic signed [127:0] disc, lo, hi, mid, two_a, n1, n2, num;
      logic signed [127:0] qx, qy;
      logic v1, v2;
      hit_type h;
      h = '0;
      dx = longint'(q.end_x) - longint'(q.start_x);
      dy = longint'(q.end_y) - longint'(q.start_y);
      ex = longint'(q.start_x) - longint'(q.centre_x);
      ey = longint'(q.start_y) - longint'(q.centre_y);
      rr = longint'(q.radius);
      a = dx * dx + dy * dy;
      b = 2 * (dx * ex + dy * ey);
      c = ex * ex + ey * ey - rr * rr;
      if (a == 0) begin
         h.status = segci_pkg::STATUS_DEGEN;
         return h;
      end
      disc = 128'(b) * 128'(b) - 128'(4) * 128'(a) * 128'(c);
      if (disc < 0) begin
         h.status = segci_pkg::STATUS_NO_ROOT;
         return h;
      end
      lo = 0;
      hi = 128'sd1 <<< 54;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (mid * mid <= disc) lo = mid;
         else hi = mid;
      end
      two_a = 128'(2 * a);
      n1 = -128'(b) + lo;
      n2 = -128'(b) - lo;
      v1 = (n1 >= 0) && (n1 <= two_a);
      v2 = (n2 >= 0) && (n2 <= two_a);
      if (v1 == v2) begin
         h.status = segci_pkg::STATUS_AMBIG;
         return h;
      end
      num = v1 ? n1 : n2;
      qx = (128'(q.start_x) * two_a + 128'(dx) * num) / two_a;
      qy = (128'(q.start_y) * two_a + 128'(dy) * num) / two_a;
      h.hit_x = qx[CW-1:0];
      h.hit_y = qy[CW-1:0];
      h.status = segci_pkg::STATUS_OK;
      return h;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CW-1:0];
   endfunction

   function automatic query_type make_query(input longint sx, sy, ex, ey, cx, cy, r);
      query_type q;
      q.start_x = clamp_coord(sx);
      q.start_y = clamp_coord(sy);
      q.end_x = clamp_coord(ex);
      q.end_y = clamp_coord(ey);
      q.centre_x = clamp_coord(cx);
      q.centre_y = clamp_coord(cy);
      q.radius = r[CW-2:0];
      return q;
   endfunction

   // mostly segments starting inside the circle, plus tiny grids and raw noise
   function automatic query_type random_query();
      query_type q;
      longint cx, cy, r, hr;
      int kind;
      kind = $urandom_range(99);
      if (kind < 55) begin
         cx = longint'($urandom_range(32000)) - 16000;
         cy = longint'($urandom_range(32000)) - 16000;
         r = (kind < 10) ? longint'($urandom_range(32767, 1))
                         : longint'($urandom_range(($urandom_range(1) != 0) ? 60 : 9000, 1));
         hr = r / 2;
         q = make_query(cx + longint'($urandom_range(2 * hr)) - hr,
                        cy + longint'($urandom_range(2 * hr)) - hr,
                        cx + longint'($urandom_range(4 * r + 4)) - 2 * r - 2,
                        cy + longint'($urandom_range(4 * r + 4)) - 2 * r - 2,
                        cx, cy, r);
      end else if (kind < 80) begin
         q = make_query(longint'($urandom_range(20)) - 10, longint'($urandom_range(20)) - 10,
                        longint'($urandom_range(20)) - 10, longint'($urandom_range(20)) - 10,
                        longint'($urandom_range(8)) - 4, longint'($urandom_range(8)) - 4,
                        longint'($urandom_range(12)));
      end else begin
         q[CW*4-1:0] = {$urandom, $urandom};
         q[CW*7-2:CW*4] = (CW*3-1)'({$urandom, $urandom});
      end
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_queries.size() != 0 || req_valid || expected_hits.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      mismatch_count = 0;
      // directed words
      pending_queries.push_back(make_query(5, 5, 5, 5, 0, 0, 3));
      pending_queries.push_back(make_query(-32768, -32768, -32768, -32768, 0, 0, 0));
      pending_queries.push_back(make_query(100, 100, 200, 100, 0, 0, 10));
      pending_queries.push_back(make_query(-10, 5, 10, 5, 0, 0, 5));
      pending_queries.push_back(make_query(-10, 0, 10, 0, 0, 0, 5));
      pending_queries.push_back(make_query(0, 0, 10, 0, 0, 0, 5));
      pending_queries.push_back(make_query(0, 0, -10, -3, 0, 0, 5));
      pending_queries.push_back(make_query(1, 1, 2, 2, 0, 0, 0));
      pending_queries.push_back(make_query(0, 0, 1, 0, 0, 0, 0));
      pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 0, 0, 32767));
      pending_queries.push_back(make_query(0, 0, 32767, 32767, 0, 0, 32767));
      pending_queries.push_back(make_query(0, 0, -32768, -32768, 0, 0, 32767));
      pending_queries.push_back(make_query(32767, -32768, -32768, 32767, 32767, 32767, 32767));
      pending_queries.push_back(make_query(-32768, 0, 32767, 0, -32768, -32768, 32767));
      pending_queries.push_back(make_query(32767, 32767, -32768, -32768, -32768, -32768, 1));
      pending_queries.push_back(make_query(3, 4, 6, 8, 0, 0, 5));
      pending_queries.push_back(make_query(6, 8, 3, 4, 0, 0, 5));
      pending_queries.push_back(make_query(-1, -1, -7, 3, -2, 2, 3));
      pending_queries.push_back(make_query(0, 0, 0, 1, 0, 0, 32767));
      pending_queries.push_back(make_query(32767, 32767, 32767, 32766, -32768, -32768, 0));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
         endcase
         for (int i = 0; i < 490; i++) pending_queries.push_back(random_query());
         // full drain between phases
         wait_drained();
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         {req_start_x, req_start_y, req_end_x, req_end_y} <= '0;
         {req_centre_x, req_centre_y, req_radius} <= '0;
      end else begin
         if (req_valid && req_ready)
            expected_hits.push_back(predict_hit({req_start_x, req_start_y, req_end_x,
               req_end_y, req_centre_x, req_centre_y, req_radius}));
         if (!req_valid || req_ready) begin
            if (pending_queries.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               query_type q;
               q = pending_queries.pop_front();
               req_valid <= 1'b1;
               {req_start_x, req_start_y, req_end_x, req_end_y,
                req_centre_x, req_centre_y, req_radius} <= q;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $error("unexpected word: hit_x %0d hit_y %0d status %0d",
                      rsp_hit_x, rsp_hit_y, rsp_status);
               mismatch_count <= mismatch_count + 1;
            end else begin
               hit_type e;
               e = expected_hits.pop_front();
               if (rsp_hit_x !== e.hit_x || rsp_hit_y !== e.hit_y ||
                   rsp_status !== e.status) begin
                  mismatch_count <= mismatch_count + 1;
                  if (rsp_hit_x !== e.hit_x)
                     $error("hit_x expected %0d actual %0d", e.hit_x, rsp_hit_x);
                  if (rsp_hit_y !== e.hit_y)
                     $error("hit_y expected %0d actual %0d", e.hit_y, rsp_hit_y);
                  if (rsp_status !== e.status)
                     $error("status expected %0d actual %0d", e.status, rsp_status);
               end
            end
         end
      end
   end

endmodule
